[sv/tsp_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and helpers for the 2-opt tour improver
// no dependencies; used by tsp_ctrl, tsp_datapath and the top level
package tsp_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int COST_W       = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int PAIR_COUNT   = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int SLOT_W       = $clog2(PAIR_COUNT);
    localparam int SLOT_XW      = SLOT_W + 1;
    localparam int TOT_W        = COST_W + CNT_W;
    localparam int MIN_VERTICES = 3;

    localparam int FIELD_IDX_W  = 5;
    localparam int FIELD_VC_W   = 6;
    localparam int FIELD_COST_W = 16;
    localparam int FIELD_TOT_W  = 21;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [FIELD_VC_W-1:0] VC_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_LOAD_EDGE = 2'd0,
        OP_LOAD_TOUR = 2'd1,
        OP_RUN       = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_START  = 20'h00002,
        ST_IN_RA  = 20'h00004,
        ST_IN_RB  = 20'h00008,
        ST_IN_EC  = 20'h00010,
        ST_IN_WR  = 20'h00020,
        ST_SC_V   = 20'h00040,
        ST_SC_Z   = 20'h00080,
        ST_SC_H   = 20'h00100,
        ST_SC_K   = 20'h00200,
        ST_SC_C1  = 20'h00400,
        ST_SC_C2  = 20'h00800,
        ST_SC_DEC = 20'h01000,
        ST_RV_A   = 20'h02000,
        ST_RV_B   = 20'h04000,
        ST_RV_W1  = 20'h08000,
        ST_RV_W2  = 20'h10000,
        ST_EM_RD  = 20'h20000,
        ST_EM_LD  = 20'h40000,
        ST_EM_WT  = 20'h80000
    } t_step;

    typedef struct packed {
        logic run_req;
        logic ref_last;
        logic take_move;
        logic pass_done;
        logic swap_more;
        logic out_taken;
        logic emit_last;
    } t_status;

    // triangular slot of an unordered vertex pair
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0]   hi;
        logic [IDX_W-1:0]   lo;
        logic [SLOT_XW-1:0] tri_n;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        tri_n = SLOT_XW'(hi) * SLOT_XW'(hi - IDX_W'(1));
        return SLOT_W'(tri_n >> 1) + SLOT_W'(lo);
    endfunction

endpackage

[sv/tsp_ram.sv]
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tsp_ctrl.sv]
`timescale 1ns / 1ps
// sequencer for loads, cost init, 2-opt scan, reversal and emit
// depends on tsp_pkg
module tsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tsp_pkg::t_status i_status,
    output tsp_pkg::t_step   o_cmd,
    output logic             o_ready
);

    tsp_pkg::t_step r_state;
    tsp_pkg::t_step n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsp_pkg::ST_IDLE:   if (i_status.run_req) n_state = tsp_pkg::ST_START;
            tsp_pkg::ST_START:  n_state = tsp_pkg::ST_IN_RA;
            tsp_pkg::ST_IN_RA:  n_state = tsp_pkg::ST_IN_RB;
            tsp_pkg::ST_IN_RB:  n_state = tsp_pkg::ST_IN_EC;
            tsp_pkg::ST_IN_EC:  n_state = tsp_pkg::ST_IN_WR;
            tsp_pkg::ST_IN_WR: begin
                n_state = i_status.ref_last ? tsp_pkg::ST_SC_V : tsp_pkg::ST_IN_RA;
            end
            tsp_pkg::ST_SC_V:   n_state = tsp_pkg::ST_SC_Z;
            tsp_pkg::ST_SC_Z:   n_state = tsp_pkg::ST_SC_H;
            tsp_pkg::ST_SC_H:   n_state = tsp_pkg::ST_SC_K;
            tsp_pkg::ST_SC_K:   n_state = tsp_pkg::ST_SC_C1;
            tsp_pkg::ST_SC_C1:  n_state = tsp_pkg::ST_SC_C2;
            tsp_pkg::ST_SC_C2:  n_state = tsp_pkg::ST_SC_DEC;
            tsp_pkg::ST_SC_DEC: begin
                if (i_status.take_move) n_state = tsp_pkg::ST_RV_A;
                else if (i_status.pass_done) n_state = tsp_pkg::ST_EM_RD;
                else n_state = tsp_pkg::ST_SC_V;
            end
            tsp_pkg::ST_RV_A:   n_state = tsp_pkg::ST_RV_B;
            tsp_pkg::ST_RV_B:   n_state = tsp_pkg::ST_RV_W1;
            tsp_pkg::ST_RV_W1:  n_state = tsp_pkg::ST_RV_W2;
            tsp_pkg::ST_RV_W2: begin
                n_state = i_status.swap_more ? tsp_pkg::ST_RV_A : tsp_pkg::ST_IN_RA;
            end
            tsp_pkg::ST_EM_RD:  n_state = tsp_pkg::ST_EM_LD;
            tsp_pkg::ST_EM_LD:  n_state = tsp_pkg::ST_EM_WT;
            tsp_pkg::ST_EM_WT: begin
                if (i_status.out_taken) begin
                    n_state = i_status.emit_last ? tsp_pkg::ST_IDLE : tsp_pkg::ST_EM_RD;
                end
            end
            default:            n_state = tsp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = r_state;
    assign o_ready = (r_state == tsp_pkg::ST_IDLE);

endmodule

[sv/tsp_datapath.sv]
`timescale 1ns / 1ps
// tour, edge-cost and cached-edge memories, counters, delta and total
// depends on tsp_pkg and tsp_ram
module tsp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tsp_pkg::t_step                     i_cmd,
    input  logic [tsp_pkg::FIELD_VC_W-1:0]     i_vcount,
    input  logic                               i_valid,
    input  logic [1:0]                         i_op,
    input  logic [tsp_pkg::FIELD_IDX_W-1:0]    i_first_index,
    input  logic [tsp_pkg::FIELD_IDX_W-1:0]    i_second_index,
    input  logic [tsp_pkg::FIELD_COST_W-1:0]   i_cost_value,
    input  logic                               i_out_ready,
    output tsp_pkg::t_status                   o_status,
    output logic                               o_valid,
    output logic [tsp_pkg::FIELD_IDX_W-1:0]    o_position,
    output logic [tsp_pkg::FIELD_IDX_W-1:0]    o_vertex,
    output logic [tsp_pkg::FIELD_TOT_W-1:0]    o_tour_cost,
    output logic                               o_last
);

    localparam int IW = tsp_pkg::IDX_W;
    localparam int CW = tsp_pkg::CNT_W;
    localparam int KW = tsp_pkg::COST_W;
    localparam int TW = tsp_pkg::TOT_W;
    localparam int SW = tsp_pkg::SLOT_W;

    logic [CW-1:0] n_used;
    logic [CW-1:0] r_p, r_pend, r_i, r_j, r_a, r_b;
    logic          r_init;
    logic [IW-1:0] r_va, r_v, r_z, r_h, r_k, r_ta;
    logic          r_same;
    logic [KW-1:0] r_ti, r_tj, r_cvh;
    logic [TW-1:0] r_total;
    logic          r_out_valid, r_out_last;
    logic [CW-1:0] r_out_pos;
    logic [IW-1:0] r_out_vert;

    logic          tour_we, tec_we, edge_we;
    logic [IW-1:0] tour_waddr, tour_wdata, tour_raddr, tour_rdata;
    logic [IW-1:0] tec_waddr, tec_raddr;
    logic [KW-1:0] tec_wdata, tec_rdata;
    logic [SW-1:0] edge_waddr, edge_raddr;
    logic [KW-1:0] edge_rdata;

    logic          in_fire;
    logic          idx_ok_a, idx_ok_b;
    logic [KW-1:0] init_cost, czk;
    logic [KW:0]   sum_new, sum_old;
    logic          skip, take;
    logic [CW:0]   j_inc, i_add3, n_ext;
    logic [IW-1:0] p_next, j_next;

    function automatic logic [IW-1:0] wrap_next(input logic [CW-1:0] x,
                                                input logic [CW-1:0] n);
        logic [CW-1:0] nx;
        nx = x + CW'(1);
        return (nx == n) ? '0 : nx[IW-1:0];
    endfunction

    always_comb begin
        if (int'(i_vcount) < tsp_pkg::MIN_VERTICES) begin
            n_used = CW'(tsp_pkg::MIN_VERTICES);
        end else if (int'(i_vcount) > tsp_pkg::MAX_VERTICES) begin
            n_used = CW'(tsp_pkg::MAX_VERTICES);
        end else begin
            n_used = CW'(i_vcount);
        end
    end

    assign in_fire  = i_valid && (i_cmd == tsp_pkg::ST_IDLE);
    assign idx_ok_a = int'(i_first_index) < tsp_pkg::MAX_VERTICES;
    assign idx_ok_b = int'(i_second_index) < tsp_pkg::MAX_VERTICES;

    assign p_next = wrap_next(r_p, n_used);
    assign j_next = wrap_next(r_j, n_used);

    // delta terms, the cost of z to k arrives in the decision cycle
    assign init_cost = r_same ? '0 : edge_rdata;
    assign czk       = (r_z == r_k) ? '0 : edge_rdata;
    assign sum_new   = {1'b0, r_cvh} + {1'b0, czk};
    assign sum_old   = {1'b0, r_ti} + {1'b0, r_tj};
    assign skip      = (r_v == '0 && r_h == '0) || (r_z == '0 && r_k == '0)
                     || (r_i == '0 && r_j == n_used - CW'(1));
    assign take      = !skip && (sum_new < sum_old);

    assign j_inc  = {1'b0, r_j} + (CW+1)'(1);
    assign i_add3 = {1'b0, r_i} + (CW+1)'(3);
    assign n_ext  = {1'b0, n_used};

    assign o_status.run_req   = in_fire && (i_op == tsp_pkg::OP_RUN);
    assign o_status.ref_last  = (r_p == r_pend);
    assign o_status.take_move = take;
    assign o_status.pass_done = (j_inc >= n_ext) && (i_add3 >= n_ext);
    assign o_status.swap_more = (r_a + CW'(1)) < (r_b - CW'(1));
    assign o_status.out_taken = r_out_valid && i_out_ready;
    assign o_status.emit_last = r_out_last;

    // memory port steering
    always_comb begin
        tour_we    = 1'b0;
        tour_waddr = IW'(i_first_index);
        tour_wdata = IW'(i_second_index);
        tour_raddr = '0;
        tec_we     = 1'b0;
        tec_waddr  = r_p[IW-1:0];
        tec_wdata  = init_cost;
        tec_raddr  = '0;
        edge_we    = 1'b0;
        edge_waddr = tsp_pkg::slot_of(IW'(i_first_index), IW'(i_second_index));
        edge_raddr = '0;
        unique case (i_cmd)
            tsp_pkg::ST_IDLE: begin
                if (in_fire && i_op == tsp_pkg::OP_LOAD_EDGE) begin
                    edge_we = idx_ok_a && idx_ok_b && (i_first_index != i_second_index);
                end
                if (in_fire && i_op == tsp_pkg::OP_LOAD_TOUR) begin
                    tour_we = idx_ok_a && idx_ok_b;
                end
            end
            tsp_pkg::ST_IN_RA:  tour_raddr = r_p[IW-1:0];
            tsp_pkg::ST_IN_RB:  tour_raddr = p_next;
            tsp_pkg::ST_IN_EC:  edge_raddr = tsp_pkg::slot_of(r_va, tour_rdata);
            tsp_pkg::ST_IN_WR:  tec_we = 1'b1;
            tsp_pkg::ST_SC_V:   tour_raddr = r_i[IW-1:0];
            tsp_pkg::ST_SC_Z:   tour_raddr = r_i[IW-1:0] + IW'(1);
            tsp_pkg::ST_SC_H:   tour_raddr = r_j[IW-1:0];
            tsp_pkg::ST_SC_K: begin
                tour_raddr = j_next;
                tec_raddr  = r_i[IW-1:0];
            end
            tsp_pkg::ST_SC_C1: begin
                tec_raddr  = r_j[IW-1:0];
                edge_raddr = tsp_pkg::slot_of(r_v, r_h);
            end
            tsp_pkg::ST_SC_C2:  edge_raddr = tsp_pkg::slot_of(r_z, r_k);
            tsp_pkg::ST_RV_A:   tour_raddr = r_a[IW-1:0];
            tsp_pkg::ST_RV_B:   tour_raddr = r_b[IW-1:0];
            tsp_pkg::ST_RV_W1: begin
                tour_we    = 1'b1;
                tour_waddr = r_a[IW-1:0];
                tour_wdata = tour_rdata;
            end
            tsp_pkg::ST_RV_W2: begin
                tour_we    = 1'b1;
                tour_waddr = r_b[IW-1:0];
                tour_wdata = r_ta;
            end
            tsp_pkg::ST_EM_RD:  tour_raddr = r_p[IW-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
            r_p         <= '0;
            r_pend      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_a         <= '0;
            r_b         <= '0;
        end else begin
            unique case (i_cmd)
                tsp_pkg::ST_START: begin
                    r_total <= '0;
                    r_p     <= '0;
                    r_pend  <= n_used - CW'(1);
                    r_init  <= 1'b1;
                end
                tsp_pkg::ST_IN_WR: begin
                    if (r_init) begin
                        r_total <= r_total + TW'(init_cost);
                    end
                    r_p <= r_p + CW'(1);
                    if (r_p == r_pend) begin
                        r_i    <= '0;
                        r_j    <= CW'(2);
                        r_init <= 1'b0;
                    end
                end
                tsp_pkg::ST_SC_DEC: begin
                    if (take) begin
                        r_total <= r_total - (TW'(sum_old) - TW'(sum_new));
                        r_a     <= r_i + CW'(1);
                        r_b     <= r_j;
                        r_p     <= r_i;
                        r_pend  <= r_j;
                    end else if (j_inc >= n_ext) begin
                        r_i <= r_i + CW'(1);
                        r_j <= CW'(i_add3);
                        r_p <= '0;
                    end else begin
                        r_j <= CW'(j_inc);
                    end
                end
                tsp_pkg::ST_RV_W2: begin
                    r_a <= r_a + CW'(1);
                    r_b <= r_b - CW'(1);
                end
                tsp_pkg::ST_EM_LD:  r_out_valid <= 1'b1;
                tsp_pkg::ST_EM_WT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_p         <= r_p + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload captures
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            tsp_pkg::ST_IN_RB:  r_va <= tour_rdata;
            tsp_pkg::ST_IN_EC:  r_same <= (r_va == tour_rdata);
            tsp_pkg::ST_SC_Z:   r_v <= tour_rdata;
            tsp_pkg::ST_SC_H:   r_z <= tour_rdata;
            tsp_pkg::ST_SC_K:   r_h <= tour_rdata;
            tsp_pkg::ST_SC_C1: begin
                r_k  <= tour_rdata;
                r_ti <= tec_rdata;
            end
            tsp_pkg::ST_SC_C2: begin
                r_tj  <= tec_rdata;
                r_cvh <= (r_v == r_h) ? '0 : edge_rdata;
            end
            tsp_pkg::ST_RV_B:   r_ta <= tour_rdata;
            tsp_pkg::ST_EM_LD: begin
                r_out_pos  <= r_p;
                r_out_vert <= tour_rdata;
                r_out_last <= (r_p == n_used - CW'(1));
            end
            default: begin
            end
        endcase
    end

    tsp_ram #(.WIDTH(IW), .DEPTH(tsp_pkg::MAX_VERTICES)) u_tour_ram (
        .i_clk   (i_clk),
        .i_we    (tour_we),
        .i_waddr (tour_waddr),
        .i_wdata (tour_wdata),
        .i_raddr (tour_raddr),
        .o_rdata (tour_rdata)
    );

    tsp_ram #(.WIDTH(KW), .DEPTH(tsp_pkg::MAX_VERTICES)) u_tec_ram (
        .i_clk   (i_clk),
        .i_we    (tec_we),
        .i_waddr (tec_waddr),
        .i_wdata (tec_wdata),
        .i_raddr (tec_raddr),
        .o_rdata (tec_rdata)
    );

    tsp_ram #(.WIDTH(KW), .DEPTH(tsp_pkg::PAIR_COUNT)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (KW'(i_cost_value)),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    assign o_valid     = r_out_valid;
    assign o_position  = tsp_pkg::FIELD_IDX_W'(r_out_pos);
    assign o_vertex    = tsp_pkg::FIELD_IDX_W'(r_out_vert);
    assign o_tour_cost = tsp_pkg::FIELD_TOT_W'(r_total);
    assign o_last      = r_out_last;

endmodule

[sv/tsp_two_opt_improver_top.sv]
`timescale 1ns / 1ps
// top level of the 2-opt tour improver: apb register, controller, datapath
// depends on tsp_pkg, tsp_ctrl, tsp_datapath
//
// first-improvement 2-opt local search on a closed tour of up to 32 vertices.
// load requests (op 0 edge cost, op 1 tour position) are taken one per cycle
// while idle and write the triangular edge-cost memory or the tour memory
// directly. a run request (op 2) first caches the cost of every tour edge and
// the total (states in_ra to in_wr per position), then scans position pairs
// i < j-1, skipping the wrap pair (states sc_v to sc_dec per pair); every
// pair costs several single-port reads of the tour, cached-edge and edge-cost
// memories. on the first gain it reverses positions i+1..j (states rv_a to
// rv_w2 per swapped pair), refreshes the cached edges i..j and restarts the
// scan. the run therefore takes a data-dependent number of cycles. when a
// pass finds no gain the tour is emitted in position order, one result at a
// time, with the final total cost and last set on the final position. no
// request is taken during a run. vertex_count (apb address 0, reset 32) is
// clamped to 3..32 and must only be written while the block is idle.
module tsp_two_opt_improver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsp_pkg::PADDR_W-1:0]         paddr,
    input  logic [tsp_pkg::PDATA_W-1:0]         pwdata,
    output logic [tsp_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // request channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [tsp_pkg::FIELD_IDX_W-1:0]     i_first_index,
    input  logic [tsp_pkg::FIELD_IDX_W-1:0]     i_second_index,
    input  logic [tsp_pkg::FIELD_COST_W-1:0]    i_cost_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tsp_pkg::FIELD_IDX_W-1:0]     o_position,
    output logic [tsp_pkg::FIELD_IDX_W-1:0]     o_vertex,
    output logic [tsp_pkg::FIELD_TOT_W-1:0]     o_tour_cost,
    output logic                                o_last
);

    logic [tsp_pkg::FIELD_VC_W-1:0] r_vcount;
    tsp_pkg::t_status               status;
    tsp_pkg::t_step                 cmd;

    // vertex_count register, written on the apb access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= tsp_pkg::VC_RESET;
        end else if (psel && penable && pwrite && paddr == tsp_pkg::ADDR_VERTEX_COUNT) begin
            r_vcount <= pwdata[tsp_pkg::FIELD_VC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == tsp_pkg::ADDR_VERTEX_COUNT)
                  ? tsp_pkg::PDATA_W'(r_vcount) : '0;

    tsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd),
        .o_ready  (o_ready)
    );

    tsp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_vcount       (r_vcount),
        .i_valid        (i_valid),
        .i_op           (i_op),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .i_cost_value   (i_cost_value),
        .i_out_ready    (i_ready),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_vertex       (o_vertex),
        .o_tour_cost    (o_tour_cost),
        .o_last         (o_last)
    );

endmodule
